// File: rtl/core/iorb_pkg.sv
// ----------------------------------------------------------------------------
// iorb_pkg
// Shared types and codes for the in-order result reorder buffer.
// ----------------------------------------------------------------------------
package iorb_pkg;

  localparam int IdxW = 32;
  localparam int PayW = 64;

  localparam logic [1:0] ST_IN_ORDER = 2'd0;
  localparam logic [1:0] ST_BEHIND   = 2'd1;
  localparam logic [1:0] ST_BEYOND   = 2'd2;

  typedef enum logic [1:0] {
    CLS_EMIT,
    CLS_HOLD,
    CLS_REJECT
  } in_class_t;

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } ctrl_state_t;

  typedef struct packed {
    in_class_t in_class;
    logic      next_held;
    logic      out_free;
  } dp_stat_t;

  typedef struct packed {
    logic emit_in;
    logic emit_slot;
    logic hold;
    logic reject;
    logic last;
  } dp_cmd_t;

endpackage

// File: rtl/core/in_order_result_reorder_buffer_core.sv
// ----------------------------------------------------------------------------
// in_order_result_reorder_buffer_core
// A request that is emitted or rejected has its first result registered in the next cycle.
// Throughput, when out_stall allows: one request per cycle if it holds or
// rejects; an in-order request that releases held items gives one result
// per cycle from the slot RAM read port, then the next request is taken.
// Reset: synchronous, active low; expected index 0, window empty.
// ----------------------------------------------------------------------------
module in_order_result_reorder_buffer_core
  import iorb_pkg::*;
#(
  parameter int WINDOW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [IdxW-1:0] cfg_start_index,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [IdxW-1:0] in_seq_index,
  input  logic            in_is_empty,
  input  logic [PayW-1:0] in_payload,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [IdxW-1:0] out_index,
  output logic            out_empty,
  output logic [PayW-1:0] out_payload,
  output logic [1:0]      out_status,
  output logic            out_last
);

  dp_stat_t stat;
  dp_cmd_t  cmd;

  iorb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .stat      (stat),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready)
  );

  iorb_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_start_index (cfg_start_index),
    .in_seq_index    (in_seq_index),
    .in_is_empty     (in_is_empty),
    .in_payload      (in_payload),
    .out_stall       (out_stall),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_index       (out_index),
    .out_empty       (out_empty),
    .out_payload     (out_payload),
    .out_status      (out_status),
    .out_last        (out_last)
  );

endmodule

// File: rtl/core/iorb_ram.sv
// ----------------------------------------------------------------------------
// iorb_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module iorb_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/iorb_ctrl.sv
// ----------------------------------------------------------------------------
// iorb_ctrl
// Controller: sequences accept, hold, reject and drain of held requests.
// ----------------------------------------------------------------------------
module iorb_ctrl
  import iorb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     in_stall,
  output logic     cfg_ready
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_stall  = !stat.out_free;
        if (in_valid && stat.out_free) begin
          case (stat.in_class)
            CLS_EMIT: begin
              cmd.emit_in = 1'b1;
              cmd.last    = !stat.next_held;
              if (stat.next_held) begin
                state_nxt = S_DRAIN;
              end
            end
            CLS_HOLD: begin
              cmd.hold = 1'b1;
            end
            default: begin
              cmd.reject = 1'b1;
              cmd.last   = 1'b1;
            end
          endcase
        end
      end
      S_DRAIN: begin
        if (stat.out_free) begin
          cmd.emit_slot = 1'b1;
          cmd.last      = !stat.next_held;
          if (!stat.next_held) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/iorb_dp.sv
// ----------------------------------------------------------------------------
// iorb_dp
// Datapath: expected index, window head, slot valid bits, slot store and
// output register.
// ----------------------------------------------------------------------------
module iorb_dp
  import iorb_pkg::*;
#(
  parameter int WINDOW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [IdxW-1:0] cfg_start_index,
  input  logic [IdxW-1:0] in_seq_index,
  input  logic            in_is_empty,
  input  logic [PayW-1:0] in_payload,
  input  logic            out_stall,
  input  dp_cmd_t         cmd,
  output dp_stat_t        stat,
  output logic            out_valid,
  output logic [IdxW-1:0] out_index,
  output logic            out_empty,
  output logic [PayW-1:0] out_payload,
  output logic [1:0]      out_status,
  output logic            out_last
);

  localparam int HW = $clog2(WINDOW);
  localparam logic [IdxW-1:0] WinLen = IdxW'(WINDOW);
  localparam logic [HW:0] WinSum = (HW + 1)'(WINDOW);
  localparam logic [HW-1:0] HeadMax = HW'(WINDOW - 1);

  logic [IdxW-1:0]   expected_r, expected_nxt;
  logic [HW-1:0]     head_r, head_nxt, head_inc;
  logic [WINDOW-1:0] valid_r, valid_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [IdxW-1:0] out_index_r;
  logic            out_empty_r;
  logic [PayW-1:0] out_payload_r;
  logic [1:0]      out_status_r;
  logic            out_last_r;

  logic [IdxW-1:0] idx, delta;
  logic [PayW-1:0] pay_in;
  logic [HW:0]     slot_sum;
  logic [HW-1:0]   slot;
  logic [PayW:0]   rdata;
  logic            advance;

  assign idx      = in_is_empty ? expected_r : in_seq_index;
  assign delta    = idx - expected_r;
  assign pay_in   = in_is_empty ? '0 : in_payload;
  assign slot_sum = {1'b0, head_r} + {1'b0, delta[HW-1:0]};
  assign slot     = (slot_sum >= WinSum) ? HW'(slot_sum - WinSum) : slot_sum[HW-1:0];
  assign head_inc = (head_r == HeadMax) ? '0 : head_r + 1'b1;
  assign advance  = cmd.emit_in | cmd.emit_slot;

  always_comb begin
    if (delta == '0) begin
      stat.in_class = CLS_EMIT;
    end else if (delta < WinLen) begin
      stat.in_class = CLS_HOLD;
    end else begin
      stat.in_class = CLS_REJECT;
    end
    stat.next_held = valid_r[head_inc];
    stat.out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    expected_nxt = expected_r;
    head_nxt     = head_r;
    valid_nxt    = valid_r;
    if (cfg_we) begin
      expected_nxt = cfg_start_index;
      head_nxt     = '0;
      valid_nxt    = '0;
    end else begin
      if (advance) begin
        valid_nxt[head_r] = 1'b0;
        expected_nxt      = expected_r + 1'b1;
        head_nxt          = head_inc;
      end
      if (cmd.hold) begin
        valid_nxt[slot] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= '0;
      head_r     <= '0;
      valid_r    <= '0;
    end else begin
      expected_r <= expected_nxt;
      head_r     <= head_nxt;
      valid_r    <= valid_nxt;
    end
  end

  iorb_ram #(
    .WIDTH (PayW + 1),
    .DEPTH (WINDOW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (cmd.hold),
    .waddr (slot),
    .wdata ({in_is_empty, pay_in}),
    .raddr (head_nxt),
    .rdata (rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.emit_in || cmd.emit_slot || cmd.reject) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_in) begin
      out_index_r   <= idx;
      out_empty_r   <= in_is_empty;
      out_payload_r <= pay_in;
      out_status_r  <= ST_IN_ORDER;
      out_last_r    <= cmd.last;
    end else if (cmd.reject) begin
      out_index_r   <= in_seq_index;
      out_empty_r   <= in_is_empty;
      out_payload_r <= pay_in;
      out_status_r  <= delta[IdxW-1] ? ST_BEHIND : ST_BEYOND;
      out_last_r    <= 1'b1;
    end else if (cmd.emit_slot) begin
      out_index_r   <= expected_r;
      out_empty_r   <= rdata[PayW];
      out_payload_r <= rdata[PayW-1:0];
      out_status_r  <= ST_IN_ORDER;
      out_last_r    <= cmd.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_index   = out_index_r;
  assign out_empty   = out_empty_r;
  assign out_payload = out_payload_r;
  assign out_status  = out_status_r;
  assign out_last    = out_last_r;

endmodule
